@@ rtl/md5sh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_pkg
// shared types, constants and step tables of the md5 stream hasher
// ----------------------------------------------------------------------------
package md5sh_pkg;

   typedef logic [3:0][31:0] word4_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   // write requests into the block buffer
   typedef struct packed {
      logic        byte_en;
      logic [5:0]  byte_pos;
      logic [7:0]  byte_data;
      logic        len_en;
      logic [63:0] len;
   } buf_wr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_FINAL,
      S_PAD,
      S_LEN,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PAD_IDLE,
      PAD_FILL,
      PAD_ZERO,
      PAD_LEN
   } pad_phase_type;

   localparam word4_type CHAIN_INIT = {32'h10325476, 32'h98badcfe,
                                       32'hefcdab89, 32'h67452301};

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [5:0] LAST_POS  = 6'd63;
   localparam logic [5:0] LEN_POS   = 6'd55;
   localparam logic [5:0] LAST_STEP = 6'd63;
   localparam logic [3:0] LEN_LO_WORD = 4'd14;
   localparam logic [3:0] LEN_HI_WORD = 4'd15;

   localparam logic [31:0] STEP_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // message word used by a step
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] ri;
      logic [3:0] idx;
      ri = step[3:0];
      case (step[5:4])
         2'd0: idx = ri;
         2'd1: idx = (ri * 4'd5) + 4'd1;
         2'd2: idx = (ri * 4'd3) + 4'd5;
         default: idx = ri * 4'd7;
      endcase
      return idx;
   endfunction

   // left rotate amount of a step
   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      logic [4:0] s;
      case ({step[5:4], step[1:0]})
         4'h0: s = 5'd7;
         4'h1: s = 5'd12;
         4'h2: s = 5'd17;
         4'h3: s = 5'd22;
         4'h4: s = 5'd5;
         4'h5: s = 5'd9;
         4'h6: s = 5'd14;
         4'h7: s = 5'd20;
         4'h8: s = 5'd4;
         4'h9: s = 5'd11;
         4'ha: s = 5'd16;
         4'hb: s = 5'd23;
         4'hc: s = 5'd6;
         4'hd: s = 5'd10;
         4'he: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/md5sh_block_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_block_buf
// sixteen-word message block, byte and length writes, one read port
// ----------------------------------------------------------------------------
module md5sh_block_buf (
   input  logic                   clock,
   input  md5sh_pkg::buf_wr_type  wr,
   input  logic [3:0]             rd_addr,
   output logic [31:0]            rd_data
);

   logic [31:0] words_ff [16];
   logic [31:0] words_in [16];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         words_in[i] = words_ff[i];
      end
      if (wr.byte_en) begin
         // lane zero starts a fresh word
         if (wr.byte_pos[1:0] == 2'd0) begin
            words_in[wr.byte_pos[5:2]] = {24'd0, wr.byte_data};
         end else begin
            words_in[wr.byte_pos[5:2]][{wr.byte_pos[1:0], 3'b000} +: 8] = wr.byte_data;
         end
      end
      if (wr.len_en) begin
         words_in[md5sh_pkg::LEN_LO_WORD] = wr.len[31:0];
         words_in[md5sh_pkg::LEN_HI_WORD] = wr.len[63:32];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         words_ff[i] <= words_in[i];
      end
   end

   assign rd_data = words_ff[rd_addr];

endmodule

@@ rtl/md5sh_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_round
// one md5 step on the working words, reused for all 64 steps
// ----------------------------------------------------------------------------
module md5sh_round (
   input  logic [5:0]              step,
   input  md5sh_pkg::word4_type    work,
   input  logic [31:0]             msg_word,
   output md5sh_pkg::word4_type    work_next
);

   logic [31:0] a, b, c, d;
   logic [31:0] f;
   logic [31:0] t;
   logic [63:0] dbl;
   logic [4:0]  s;

   assign a = work[0];
   assign b = work[1];
   assign c = work[2];
   assign d = work[3];

   always_comb begin
      case (step[5:4])
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (b & d) | (c & ~d);
         2'd2: f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
   end

   assign t   = a + f + md5sh_pkg::STEP_K[step] + msg_word;
   assign s   = md5sh_pkg::rot_amount(step);
   assign dbl = {t, t} << s;

   assign work_next[0] = d;
   assign work_next[1] = b + dbl[63:32];
   assign work_next[2] = b;
   assign work_next[3] = c;

endmodule

@@ rtl/md5_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher
// md5 digest of a byte stream, one shared step unit under a sequencer
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per message byte (byte_present), end_of_message
//   on the final word; a word with end mark and no byte ends the message
//   with the bytes already given, and as the first word hashes the empty
//   message. a word with neither flag is taken and does nothing.
//   rsp channel: four words per message, A, B, C, D, last_word on D.
// sequence
//   a byte that does not fill the block is written while req_ready stays
//   high; the 64th byte of a block starts a compression: the 64 steps,
//   then the chain add. at the end: padding up to byte 55 when pos < 56,
//   else padding to byte 63, a compression and a zeroed second block up
//   to byte 55; then the length, a compression and the four digest
//   words. req_ready is low meanwhile.
//   the rate is set by the single step unit and the byte-wide block writes.
// reset: synchronous; chain words go to the md5 initial values, the bit
//   count clears and the block is ready for a new message.
// stall: the digest words come straight from the chain registers and hold
//   while rsp_ready is low; no new word is taken until D is delivered.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  md5sh_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output md5sh_pkg::rsp_type  rsp_data
);

   // sequencer state
   md5sh_pkg::state_type     state_ff, state_in;
   md5sh_pkg::pad_phase_type phase_ff, phase_in;
   logic [5:0]               round_ff, round_in;
   logic [5:0]               pad_pos_ff, pad_pos_in;
   logic                     pad_first_ff, pad_first_in;
   logic                     pend_end_ff, pend_end_in;
   logic [1:0]               out_idx_ff, out_idx_in;
   logic [63:0]              bit_count_ff, bit_count_in;
   md5sh_pkg::word4_type     chain_ff, chain_in;

   // working words of the current compression
   md5sh_pkg::word4_type     work_ff, work_in;

   md5sh_pkg::buf_wr_type    buf_wr;
   md5sh_pkg::word4_type     round_out;
   logic [31:0]              msg_word;
   logic [5:0]               cur_pos;
   logic [63:0]              count_plus;

   md5sh_block_buf u_buf (
      .clock   (clock),
      .wr      (buf_wr),
      .rd_addr (md5sh_pkg::msg_index(round_ff)),
      .rd_data (msg_word)
   );

   md5sh_round u_round (
      .step      (round_ff),
      .work      (work_ff),
      .msg_word  (msg_word),
      .work_next (round_out)
   );

   assign cur_pos    = bit_count_ff[8:3];
   assign count_plus = bit_count_ff + 64'd8;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      round_in     = round_ff;
      pad_pos_in   = pad_pos_ff;
      pad_first_in = pad_first_ff;
      pend_end_in  = pend_end_ff;
      out_idx_in   = out_idx_ff;
      bit_count_in = bit_count_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      buf_wr       = '0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;

      case (state_ff)
         md5sh_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.byte_present) begin
                  buf_wr.byte_en   = 1'b1;
                  buf_wr.byte_pos  = cur_pos;
                  buf_wr.byte_data = req_data.data_byte;
                  bit_count_in     = count_plus;
                  if (cur_pos == md5sh_pkg::LAST_POS) begin
                     // block full: compress, padding waits for the end
                     work_in     = chain_ff;
                     pend_end_in = req_data.end_of_message;
                     state_in    = md5sh_pkg::S_ROUND;
                  end else if (req_data.end_of_message) begin
                     pad_pos_in   = count_plus[8:3];
                     pad_first_in = 1'b1;
                     phase_in     = md5sh_pkg::PAD_FILL;
                     state_in     = md5sh_pkg::S_PAD;
                  end
               end else if (req_data.end_of_message) begin
                  pad_pos_in   = cur_pos;
                  pad_first_in = 1'b1;
                  phase_in     = md5sh_pkg::PAD_FILL;
                  state_in     = md5sh_pkg::S_PAD;
               end
            end
         end

         md5sh_pkg::S_ROUND: begin
            work_in  = round_out;
            round_in = round_ff + 6'd1;
            if (round_ff == md5sh_pkg::LAST_STEP) begin
               state_in = md5sh_pkg::S_FINAL;
            end
         end

         md5sh_pkg::S_FINAL: begin
            for (int k = 0; k < 4; k++) begin
               chain_in[k] = chain_ff[k] + work_ff[k];
            end
            case (phase_ff)
               md5sh_pkg::PAD_IDLE: begin
                  if (pend_end_ff) begin
                     // byte with end mark filled the block
                     pend_end_in  = 1'b0;
                     pad_pos_in   = cur_pos;
                     pad_first_in = 1'b1;
                     phase_in     = md5sh_pkg::PAD_FILL;
                     state_in     = md5sh_pkg::S_PAD;
                  end else begin
                     state_in = md5sh_pkg::S_IDLE;
                  end
               end
               md5sh_pkg::PAD_FILL: begin
                  // length did not fit: zero a second block
                  pad_pos_in = 6'd0;
                  phase_in   = md5sh_pkg::PAD_ZERO;
                  state_in   = md5sh_pkg::S_PAD;
               end
               md5sh_pkg::PAD_LEN: begin
                  out_idx_in = 2'd0;
                  state_in   = md5sh_pkg::S_OUT;
               end
               default: begin
                  state_in = md5sh_pkg::S_IDLE;
               end
            endcase
         end

         md5sh_pkg::S_PAD: begin
            buf_wr.byte_en   = 1'b1;
            buf_wr.byte_pos  = pad_pos_ff;
            buf_wr.byte_data = pad_first_ff ? md5sh_pkg::PAD_MARK : 8'd0;
            pad_first_in     = 1'b0;
            if (pad_pos_ff == md5sh_pkg::LEN_POS) begin
               state_in = md5sh_pkg::S_LEN;
            end else if (pad_pos_ff == md5sh_pkg::LAST_POS) begin
               work_in  = chain_ff;
               state_in = md5sh_pkg::S_ROUND;
            end else begin
               pad_pos_in = pad_pos_ff + 6'd1;
            end
         end

         md5sh_pkg::S_LEN: begin
            buf_wr.len_en = 1'b1;
            buf_wr.len    = bit_count_ff;
            phase_in      = md5sh_pkg::PAD_LEN;
            work_in       = chain_ff;
            state_in      = md5sh_pkg::S_ROUND;
         end

         md5sh_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 2'd1;
               if (out_idx_ff == 2'd3) begin
                  // digest delivered: back to a fresh message
                  chain_in     = md5sh_pkg::CHAIN_INIT;
                  bit_count_in = 64'd0;
                  phase_in     = md5sh_pkg::PAD_IDLE;
                  pend_end_in  = 1'b0;
                  state_in     = md5sh_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = md5sh_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md5sh_pkg::S_IDLE;
         phase_ff     <= md5sh_pkg::PAD_IDLE;
         round_ff     <= 6'd0;
         pad_pos_ff   <= 6'd0;
         pad_first_ff <= 1'b0;
         pend_end_ff  <= 1'b0;
         out_idx_ff   <= 2'd0;
         bit_count_ff <= 64'd0;
         chain_ff     <= md5sh_pkg::CHAIN_INIT;
         work_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         round_ff     <= round_in;
         pad_pos_ff   <= pad_pos_in;
         pad_first_ff <= pad_first_in;
         pend_end_ff  <= pend_end_in;
         out_idx_ff   <= out_idx_in;
         bit_count_ff <= bit_count_in;
         chain_ff     <= chain_in;
         work_ff      <= work_in;
      end
   end

   assign rsp_data.digest_word = chain_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last_word   = (out_idx_ff == 2'd3);

   // the step counter only runs inside a compression
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != md5sh_pkg::S_ROUND) |-> (round_ff == 6'd0))
      else $error("step counter nonzero outside compression");

   // the length is only written once padding has reached byte 55
   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == md5sh_pkg::S_LEN) |-> (pad_pos_ff == md5sh_pkg::LEN_POS))
      else $error("length written at wrong pad position");

   // input and output sides are never open together
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while digest pending");

   // the final digest word returns the hasher to a fresh message
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_word) |=>
         (req_ready && bit_count_ff == 64'd0 && chain_ff == md5sh_pkg::CHAIN_INIT))
      else $error("state not cleared after digest");

endmodule
